@@ sv/alu8_pkg.sv @@
package alu8_pkg;

  // field widths
  localparam int OP_W   = 5;
  localparam int DATA_W = 8;
  localparam int FLAG_W = 4;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
  localparam logic [OP_W-1:0] OP_ADC  = 5'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 5'd2;
  localparam logic [OP_W-1:0] OP_SBC  = 5'd3;
  localparam logic [OP_W-1:0] OP_AND  = 5'd4;
  localparam logic [OP_W-1:0] OP_XOR  = 5'd5;
  localparam logic [OP_W-1:0] OP_OR   = 5'd6;
  localparam logic [OP_W-1:0] OP_CP   = 5'd7;
  localparam logic [OP_W-1:0] OP_INC  = 5'd8;
  localparam logic [OP_W-1:0] OP_DEC  = 5'd9;
  localparam logic [OP_W-1:0] OP_RLC  = 5'd10;
  localparam logic [OP_W-1:0] OP_RL   = 5'd11;
  localparam logic [OP_W-1:0] OP_RRC  = 5'd12;
  localparam logic [OP_W-1:0] OP_RR   = 5'd13;
  localparam logic [OP_W-1:0] OP_RLCA = 5'd14;
  localparam logic [OP_W-1:0] OP_RLA  = 5'd15;
  localparam logic [OP_W-1:0] OP_RRCA = 5'd16;
  localparam logic [OP_W-1:0] OP_RRA  = 5'd17;
  localparam logic [OP_W-1:0] OP_DAA  = 5'd18;
  localparam logic [OP_W-1:0] OP_CPL  = 5'd19;
  localparam logic [OP_W-1:0] OP_SCF  = 5'd20;
  localparam logic [OP_W-1:0] OP_CCF  = 5'd21;

  // rotate kinds, taken from the code offset to RLC
  localparam logic [1:0] ROT_RLC = 2'd0;
  localparam logic [1:0] ROT_RL  = 2'd1;
  localparam logic [1:0] ROT_RRC = 2'd2;
  localparam logic [1:0] ROT_RR  = 2'd3;

  // flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // decimal adjust constants
  localparam logic [DATA_W-1:0] DAA_LO     = 8'h06;
  localparam logic [DATA_W-1:0] DAA_HI     = 8'h60;
  localparam logic [DATA_W-1:0] DAA_LIMIT  = 8'h99;
  localparam logic [3:0]        NIBBLE_MAX = 4'h9;

endpackage

@@ sv/alu8_if.sv @@
interface alu8_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [alu8_pkg::OP_W-1:0]      operation;
  logic [alu8_pkg::DATA_W-1:0]    first_operand;
  logic [alu8_pkg::DATA_W-1:0]    second_operand;
  logic [alu8_pkg::FLAG_W-1:0]    flags_in;

  modport source (output valid, operation, first_operand, second_operand, flags_in,
                  input ready);
  modport sink   (input valid, operation, first_operand, second_operand, flags_in,
                  output ready);
endinterface

interface alu8_res_if;
  logic                           valid;
  logic                           ready;
  logic [alu8_pkg::DATA_W-1:0]    result;
  logic [alu8_pkg::FLAG_W-1:0]    flags_out;

  modport source (output valid, result, flags_out, input ready);
  modport sink   (input valid, result, flags_out, output ready);
endinterface

@@ sv/eight_bit_alu_with_flags.sv @@
// 8-bit alu with z n h c flags, one input register and one result register
// an accepted command passes the input register, then the result register
// throughput: one beat per cycle unless res.ready stalls the result stage;
//   the alu logic holds separate 9-bit add and subtract/compare paths
// reset: synchronous active-high rst empties both register stages
module eight_bit_alu_with_flags (
  input  logic       clk,
  input  logic       rst,
  alu8_cmd_if.sink   cmd,
  alu8_res_if.source res
);

  // input stage registers
  logic                          s1_valid;
  logic [alu8_pkg::OP_W-1:0]     s1_op;
  logic [alu8_pkg::DATA_W-1:0]   s1_a;
  logic [alu8_pkg::DATA_W-1:0]   s1_b;
  logic [alu8_pkg::FLAG_W-1:0]   s1_f;

  // result stage registers
  logic                          o_valid;
  logic [alu8_pkg::DATA_W-1:0]   o_result;
  logic [alu8_pkg::FLAG_W-1:0]   o_flags;

  logic s2_en;
  logic s1_en;

  // stage enables
  assign s2_en     = !o_valid || res.ready;
  assign s1_en     = !s1_valid || s2_en;
  assign cmd.ready = s1_en;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= cmd.valid;
    end
    if (s1_en && cmd.valid) begin
      s1_op <= cmd.operation;
      s1_a  <= cmd.first_operand;
      s1_b  <= cmd.second_operand;
      s1_f  <= cmd.flags_in;
    end
  end

  // alu datapath
  logic [alu8_pkg::DATA_W-1:0] r_next;
  logic [alu8_pkg::FLAG_W-1:0] f_next;
  logic                        cin;
  logic                        cuse;
  logic [8:0]                  sum9;
  logic [4:0]                  hsum;
  logic [8:0]                  dif9;
  logic [4:0]                  hdif;
  logic [alu8_pkg::OP_W-1:0]   rot_off;
  logic [1:0]                  rot_kind;
  logic                        rot_out;
  logic [alu8_pkg::DATA_W-1:0] rot_val;
  logic [alu8_pkg::DATA_W-1:0] corr;
  logic [alu8_pkg::DATA_W-1:0] daa_val;

  assign cin  = s1_f[alu8_pkg::FLAG_C];
  assign cuse = (s1_op == alu8_pkg::OP_ADC || s1_op == alu8_pkg::OP_SBC) ? cin : 1'b0;
  assign sum9 = {1'b0, s1_a} + {1'b0, s1_b} + {8'd0, cuse};
  assign hsum = {1'b0, s1_a[3:0]} + {1'b0, s1_b[3:0]} + {4'd0, cuse};
  assign dif9 = {1'b0, s1_a} - {1'b0, s1_b} - {8'd0, cuse};
  assign hdif = {1'b0, s1_a[3:0]} - {1'b0, s1_b[3:0]} - {4'd0, cuse};

  // rotate unit, shared by the prefixed and accumulator forms
  assign rot_off  = s1_op - alu8_pkg::OP_RLC;
  assign rot_kind = rot_off[1:0];

  always_comb begin
    case (rot_kind)
      alu8_pkg::ROT_RLC: begin
        rot_out = s1_a[7];
        rot_val = {s1_a[6:0], s1_a[7]};
      end
      alu8_pkg::ROT_RL: begin
        rot_out = s1_a[7];
        rot_val = {s1_a[6:0], cin};
      end
      alu8_pkg::ROT_RRC: begin
        rot_out = s1_a[0];
        rot_val = {s1_a[0], s1_a[7:1]};
      end
      default: begin
        rot_out = s1_a[0];
        rot_val = {cin, s1_a[7:1]};
      end
    endcase
  end

  // decimal adjust correction
  always_comb begin
    corr = '0;
    if (s1_f[alu8_pkg::FLAG_H] ||
        (!s1_f[alu8_pkg::FLAG_N] && s1_a[3:0] > alu8_pkg::NIBBLE_MAX)) begin
      corr = corr | alu8_pkg::DAA_LO;
    end
    if (s1_f[alu8_pkg::FLAG_C] ||
        (!s1_f[alu8_pkg::FLAG_N] && s1_a > alu8_pkg::DAA_LIMIT)) begin
      corr = corr | alu8_pkg::DAA_HI;
    end
    daa_val = s1_f[alu8_pkg::FLAG_N] ? (s1_a - corr) : (s1_a + corr);
  end

  // operation select
  always_comb begin
    r_next = s1_a;
    f_next = s1_f;
    unique case (s1_op) inside
      alu8_pkg::OP_ADD, alu8_pkg::OP_ADC: begin
        r_next = sum9[7:0];
        f_next = {sum9[7:0] == 8'd0, 1'b0, hsum[4], sum9[8]};
      end
      alu8_pkg::OP_SUB, alu8_pkg::OP_SBC, alu8_pkg::OP_CP: begin
        r_next = (s1_op == alu8_pkg::OP_CP) ? s1_a : dif9[7:0];
        f_next = {dif9[7:0] == 8'd0, 1'b1, hdif[4], dif9[8]};
      end
      alu8_pkg::OP_AND: begin
        r_next = s1_a & s1_b;
        f_next = {(s1_a & s1_b) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      alu8_pkg::OP_XOR: begin
        r_next = s1_a ^ s1_b;
        f_next = {(s1_a ^ s1_b) == 8'd0, 3'b000};
      end
      alu8_pkg::OP_OR: begin
        r_next = s1_a | s1_b;
        f_next = {(s1_a | s1_b) == 8'd0, 3'b000};
      end
      alu8_pkg::OP_INC: begin
        r_next = s1_a + 8'd1;
        f_next = {s1_a == 8'hff, 1'b0, s1_a[3:0] == 4'hf, cin};
      end
      alu8_pkg::OP_DEC: begin
        r_next = s1_a - 8'd1;
        f_next = {s1_a == 8'h01, 1'b1, s1_a[3:0] == 4'h0, cin};
      end
      [alu8_pkg::OP_RLC:alu8_pkg::OP_RR]: begin
        r_next = rot_val;
        f_next = {rot_val == 8'd0, 2'b00, rot_out};
      end
      [alu8_pkg::OP_RLCA:alu8_pkg::OP_RRA]: begin
        r_next = rot_val;
        f_next = {3'b000, rot_out};
      end
      alu8_pkg::OP_DAA: begin
        r_next = daa_val;
        f_next = {daa_val == 8'd0, s1_f[alu8_pkg::FLAG_N], 1'b0,
                  (corr & alu8_pkg::DAA_HI) != 8'd0};
      end
      alu8_pkg::OP_CPL: begin
        r_next = ~s1_a;
        f_next = {s1_f[alu8_pkg::FLAG_Z], 2'b11, cin};
      end
      alu8_pkg::OP_SCF: begin
        f_next = {s1_f[alu8_pkg::FLAG_Z], 3'b001};
      end
      alu8_pkg::OP_CCF: begin
        f_next = {s1_f[alu8_pkg::FLAG_Z], 2'b00, !cin};
      end
      default: begin
        r_next = s1_a;
        f_next = s1_f;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s2_en) begin
      o_valid <= s1_valid;
    end
    if (s2_en && s1_valid) begin
      o_result <= r_next;
      o_flags  <= f_next;
    end
  end

  assign res.valid     = o_valid;
  assign res.result    = o_result;
  assign res.flags_out = o_flags;

  // an empty input stage always takes a beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> cmd.ready)
    else $error("command stalled with empty input stage");

  // a held item reaches the result register when the output side moves
  a_item_advances: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_en |=> res.valid)
    else $error("item lost between stages");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && !s1_valid |=> !res.valid)
    else $error("result repeated");

  // compare passes the accumulator through and sets subtract
  a_cp_passthrough: assert property (@(posedge clk) disable iff (rst)
    s2_en && s1_valid && s1_op == alu8_pkg::OP_CP |=>
      res.result == $past(s1_a) && res.flags_out[alu8_pkg::FLAG_N])
    else $error("compare changed its operand");

endmodule
